@@ sv/cpc_pkg.sv @@
// Shared constants and types for the camera path compensation unit.
// Used by camera_path_compensation_unit; no dependencies.
package cpc_pkg;

    localparam int MAX_RADIUS  = 31;
    localparam int RING_DEPTH  = 64;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int RADIUS_W    = 5;
    localparam int FRAME_W     = 23;
    localparam int FNUM_W      = 22;
    localparam int PATH_W      = 32;
    localparam int SHIFT_W     = 20;
    localparam int SUM_W       = 40;
    localparam int CNT_W       = 6;
    localparam int DIV_STEPS   = SUM_W;
    localparam int RADIUS_CAP_I = (MAX_RADIUS < (RING_DEPTH - 1) / 2) ?
                                  MAX_RADIUS : (RING_DEPTH - 1) / 2;
    localparam int RADIUS_CAP_J = (RADIUS_CAP_I < 31) ? RADIUS_CAP_I : 31;
    localparam logic [RADIUS_W-1:0] RADIUS_CAP = RADIUS_W'(RADIUS_CAP_J);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd15;
    localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'((1 << FNUM_W) - 1);

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_TRIPOD = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_SUM   = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_TRI   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    function automatic logic [PATH_W-1:0] sat_path(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] hi_lim;
        logic [SUM_W-1:0] lo_lim;
        hi_lim = SUM_W'(34'sh0_7FFF_FFFF);
        lo_lim = {{(SUM_W-PATH_W+1){1'b1}}, {(PATH_W-1){1'b0}}};
        if ($signed(v) > $signed(hi_lim))
            sat_path = {1'b0, {(PATH_W-1){1'b1}}};
        else if ($signed(v) < $signed(lo_lim))
            sat_path = {1'b1, {(PATH_W-1){1'b0}}};
        else
            sat_path = v[PATH_W-1:0];
    endfunction

endpackage

@@ sv/cpc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/camera_path_compensation_unit.sv @@
// Camera path compensation: running path, centered box smoothing, tripod lock.
// Depends on cpc_pkg and cpc_ram.
//
// channel   dir  handshake             payload
// s_axis    in   s_axis_tvalid/tready  tdata: shift_x, shift_y; tlast: end_of_clip
// m_axis    out  m_axis_tvalid/tready  tdata: comp_x, comp_y, frame_number; tlast: final
// cfg       in   cfg_we                cfg_addr 0 radius, 1 tripod; cfg_data
//
// A smoothed result takes window setup, 2R+1 ring reads (fewer at clip edges), the
// restoring divider (one quotient bit a cycle on 40 bits) and the output stage; a flush
// repeats these steps for each further pending frame. Tripod results pass through S_TRI
// and S_EMIT into the output register. Input is taken only while the engine idles; a
// stalled output holds the engine in its output stage. Reset clears control state; the
// path ring needs no clearing.
module camera_path_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // shift_x[19:0], shift_y[39:20]
    input  logic        s_axis_tlast,   // end_of_clip
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // comp_x[31:0], comp_y[63:32], frame_number[85:64]
    output logic        m_axis_tlast,   // final_result
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [4:0]  cfg_data
);
    import cpc_pkg::*;

    state_t state_reg;

    logic [RADIUS_W-1:0] radius_cfg_reg;
    logic                tripod_cfg_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                tripod_reg;

    logic [PATH_W-1:0]  acc_reg   [2];
    logic [PATH_W-1:0]  origin_reg[2];
    logic [FRAME_W-1:0] frames_in_reg;
    logic [FRAME_W-1:0] frames_out_reg;
    logic [FRAME_W-1:0] cur_f_reg;
    logic               cur_last_reg;
    logic [FRAME_W-1:0] i_reg;
    logic [FRAME_W-1:0] rd_j_reg;
    logic [FRAME_W-1:0] hi_reg;
    logic               rd_done_reg;
    logic               pend_reg;
    logic               pend_i_reg;
    logic               pend_last_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [SUM_W-1:0]   sum_reg [2];
    logic [PATH_W-1:0]  p_reg   [2];
    logic               neg_reg [2];
    logic [SUM_W-1:0]   dq_reg  [2];
    logic [CNT_W-1:0]   rem_reg [2];
    logic [CNT_W-1:0]   div_cnt_reg;
    logic [PATH_W-1:0]  res_reg [2];

    logic [PATH_W-1:0]  out_x_reg;
    logic [PATH_W-1:0]  out_y_reg;
    logic [FNUM_W-1:0]  out_fn_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    // ring port
    logic                  ram_we;
    logic [RING_AW-1:0]    ram_waddr;
    logic [2*PATH_W-1:0]   ram_wdata;
    logic [RING_AW-1:0]    ram_raddr;
    logic [2*PATH_W-1:0]   ram_rdata;

    logic                  in_xfer;
    logic [PATH_W-1:0]     acc_new[2];
    logic [SHIFT_W-1:0]    shift_in[2];
    logic [RADIUS_W-1:0]   r_eff;
    logic                  tripod_eff;
    logic                  last_in;
    logic                  out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign shift_in[0]   = s_axis_tdata[19:0];
    assign shift_in[1]   = s_axis_tdata[39:20];
    assign last_in       = s_axis_tlast || (frames_in_reg == FRAME_LAST);
    assign r_eff         = (frames_in_reg == '0) ?
                           ((radius_cfg_reg > RADIUS_CAP) ? RADIUS_CAP : radius_cfg_reg) :
                           radius_reg;
    assign tripod_eff    = (frames_in_reg == '0) ? tripod_cfg_reg : tripod_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            logic [PATH_W:0] s33;
            s33 = {acc_reg[k][PATH_W-1], acc_reg[k]}
                  + {{(PATH_W-SHIFT_W+1){shift_in[k][SHIFT_W-1]}}, shift_in[k]};
            if (s33[PATH_W] != s33[PATH_W-1])
                acc_new[k] = s33[PATH_W] ? {1'b1, {(PATH_W-1){1'b0}}}
                                         : {1'b0, {(PATH_W-1){1'b1}}};
            else
                acc_new[k] = s33[PATH_W-1:0];
        end
    end

    assign ram_we    = in_xfer;
    assign ram_waddr = frames_in_reg[RING_AW-1:0];
    assign ram_wdata = {acc_new[1], acc_new[0]};
    assign ram_raddr = rd_j_reg[RING_AW-1:0];

    cpc_ram #(
        .WIDTH (2*PATH_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_cfg_reg <= RADIUS_RESET;
            tripod_cfg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_RADIUS: radius_cfg_reg <= cfg_data;
                CFG_TRIPOD: tripod_cfg_reg <= cfg_data[0];
                default:    radius_cfg_reg <= radius_cfg_reg;
            endcase
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frames_in_reg  <= '0;
            frames_out_reg <= '0;
            radius_reg     <= '0;
            tripod_reg     <= 1'b0;
            acc_reg[0]     <= '0;
            acc_reg[1]     <= '0;
            origin_reg[0]  <= '0;
            origin_reg[1]  <= '0;
            rd_done_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        radius_reg    <= r_eff;
                        tripod_reg    <= tripod_eff;
                        acc_reg[0]    <= acc_new[0];
                        acc_reg[1]    <= acc_new[1];
                        if (frames_in_reg == '0)
                        begin
                            origin_reg[0] <= acc_new[0];
                            origin_reg[1] <= acc_new[1];
                        end
                        frames_in_reg <= frames_in_reg + 1'b1;
                        priority if (tripod_eff)
                            state_reg <= S_TRI;
                        else if (last_in || frames_in_reg >= FRAME_W'(r_eff))
                            state_reg <= S_START;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_START:
                begin
                    rd_done_reg <= 1'b0;
                    pend_reg    <= 1'b0;
                    state_reg   <= S_SUM;
                end
                S_SUM:
                begin
                    pend_reg <= !rd_done_reg;
                    if (!rd_done_reg && rd_j_reg == hi_reg)
                    begin
                        rd_done_reg <= 1'b1;
                    end
                    if (pend_reg && pend_last_reg)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:  state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_cnt_reg == CNT_W'(DIV_STEPS - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:   state_reg <= S_EMIT;
                S_TRI:   state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        priority if (!cur_last_reg)
                        begin
                            state_reg      <= S_IDLE;
                            frames_out_reg <= i_reg + 1'b1;
                        end
                        else if (!tripod_reg && i_reg != cur_f_reg)
                        begin
                            state_reg      <= S_START;
                            frames_out_reg <= i_reg + 1'b1;
                        end
                        else
                        begin
                            // end of clip: drop all clip state
                            state_reg      <= S_IDLE;
                            frames_in_reg  <= '0;
                            frames_out_reg <= '0;
                            radius_reg     <= '0;
                            tripod_reg     <= 1'b0;
                            acc_reg[0]     <= '0;
                            acc_reg[1]     <= '0;
                            origin_reg[0]  <= '0;
                            origin_reg[1]  <= '0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cur_f_reg    <= frames_in_reg;
                cur_last_reg <= last_in;
                i_reg        <= tripod_eff ? frames_in_reg : frames_out_reg;
            end
            S_START:
            begin
                logic [FRAME_W-1:0] lo;
                logic [FRAME_W-1:0] hi;
                lo = (i_reg >= FRAME_W'(radius_reg)) ? i_reg - FRAME_W'(radius_reg) : '0;
                hi = (i_reg + FRAME_W'(radius_reg) <= cur_f_reg) ?
                     i_reg + FRAME_W'(radius_reg) : cur_f_reg;
                rd_j_reg   <= lo;
                hi_reg     <= hi;
                n_reg      <= CNT_W'(hi - lo + 1'b1);
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
            end
            S_SUM:
            begin
                if (!rd_done_reg)
                begin
                    pend_i_reg    <= (rd_j_reg == i_reg);
                    pend_last_reg <= (rd_j_reg == hi_reg);
                    rd_j_reg      <= rd_j_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        sum_reg[k] <= sum_reg[k]
                            + {{(SUM_W-PATH_W){ram_rdata[k*PATH_W+PATH_W-1]}},
                               ram_rdata[k*PATH_W +: PATH_W]};
                        if (pend_i_reg)
                            p_reg[k] <= ram_rdata[k*PATH_W +: PATH_W];
                    end
                end
            end
            S_PREP:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    logic [SUM_W-1:0] mag;
                    mag = sum_reg[k][SUM_W-1] ? -sum_reg[k] : sum_reg[k];
                    neg_reg[k] <= sum_reg[k][SUM_W-1];
                    dq_reg[k]  <= mag + SUM_W'(n_reg >> 1);
                    rem_reg[k] <= '0;
                end
                div_cnt_reg <= '0;
            end
            S_DIV:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    logic [CNT_W:0] rsh;
                    logic           ge;
                    rsh = {rem_reg[k], dq_reg[k][SUM_W-1]};
                    ge  = rsh >= {1'b0, n_reg};
                    rem_reg[k] <= ge ? CNT_W'(rsh - {1'b0, n_reg}) : rsh[CNT_W-1:0];
                    dq_reg[k]  <= {dq_reg[k][SUM_W-2:0], ge};
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            S_FIN:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    logic [SUM_W-1:0] sq;
                    sq = neg_reg[k] ? -dq_reg[k] : dq_reg[k];
                    res_reg[k] <= sat_path({{(SUM_W-PATH_W){p_reg[k][PATH_W-1]}}, p_reg[k]}
                                           - sq);
                end
            end
            S_TRI:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    res_reg[k] <= sat_path(
                        {{(SUM_W-PATH_W){acc_reg[k][PATH_W-1]}}, acc_reg[k]}
                        - {{(SUM_W-PATH_W){origin_reg[k][PATH_W-1]}}, origin_reg[k]});
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_x_reg    <= res_reg[0];
                    out_y_reg    <= res_reg[1];
                    out_fn_reg   <= i_reg[FNUM_W-1:0];
                    out_last_reg <= cur_last_reg && (i_reg == cur_f_reg);
                    i_reg        <= i_reg + 1'b1;
                end
            end
            default: i_reg <= i_reg;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_fn_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_origin_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && frames_in_reg == '0) |=> (origin_reg[0] == acc_reg[0]))
        else $error("origin not taken from first frame");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (n_reg != '0))
        else $error("window count is zero in divider");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && !rd_done_reg) |-> (rd_j_reg <= hi_reg))
        else $error("ring read ran past window end");
`endif

endmodule
